// ----- design/upd_pkg.sv -----
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types and constants for the URL percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam int unsigned CapWidth    = 13;
  localparam int unsigned LenWidth    = 12;
  localparam int unsigned CharWidth   = 8;
  localparam int unsigned NibWidth    = 4;

  localparam logic [CapWidth-1:0] CapReset = 13'd2048;
  localparam logic [CapWidth-1:0] CapLimit = 13'd4096;

  localparam logic [CharWidth-1:0] ChEnd      = 8'h00;
  localparam logic [CharWidth-1:0] ChQuestion = 8'h3F;
  localparam logic [CharWidth-1:0] ChHash     = 8'h23;
  localparam logic [CharWidth-1:0] ChPercent  = 8'h25;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_END,
    KIND_STOP,
    KIND_PCT
  } kind_t;

  typedef enum logic [1:0] {
    PH_NORMAL,
    PH_HI,
    PH_LO
  } phase_t;

  typedef struct packed {
    kind_t                kind;
    logic                 hex_ok;
    logic [NibWidth-1:0]  nib;
    logic [CharWidth-1:0] ch;
  } tok_t;

endpackage

// ----- design/upd_front.sv -----
// ----------------------------------------------------------------------------
// upd_front
// Accepts characters, classifies them and holds one token for the queue.
// ----------------------------------------------------------------------------
module upd_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [upd_pkg::CharWidth-1:0] ch,
  output logic                      tok_valid,
  input  logic                      tok_ready,
  output upd_pkg::tok_t             tok
);
  import upd_pkg::*;

  tok_t tok_next;
  logic tok_valid_next;

  always_comb begin
    tok_next.ch     = ch;
    tok_next.hex_ok = 1'b1;
    tok_next.nib    = '0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      tok_next.nib = NibWidth'(ch - 8'h30);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      tok_next.nib = NibWidth'(ch - 8'h57);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      tok_next.nib = NibWidth'(ch - 8'h37);
    end else begin
      tok_next.hex_ok = 1'b0;
    end
    if (ch == ChEnd) begin
      tok_next.kind = KIND_END;
    end else if (ch == ChQuestion || ch == ChHash) begin
      tok_next.kind = KIND_STOP;
    end else if (ch == ChPercent) begin
      tok_next.kind = KIND_PCT;
    end else begin
      tok_next.kind = KIND_CHAR;
    end
  end

  assign in_ready = !tok_valid || tok_ready;

  always_comb begin
    tok_valid_next = tok_valid;
    if (in_ready) begin
      tok_valid_next = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else begin
      tok_valid <= tok_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tok <= tok_next;
    end
  end

endmodule

// ----- design/upd_queue.sv -----
// ----------------------------------------------------------------------------
// upd_queue
// Two-entry token queue between the front and back parts.
// ----------------------------------------------------------------------------
module upd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  upd_pkg::tok_t push_tok,
  output logic          pop_valid,
  input  logic          pop_ready,
  output upd_pkg::tok_t pop_tok
);
  import upd_pkg::*;

  tok_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_tok    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_tok;
    end
  end

endmodule

// ----- design/upd_back.sv -----
// ----------------------------------------------------------------------------
// upd_back
// Applies tokens to the decode state and drives the result register.
// ----------------------------------------------------------------------------
module upd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_en,
  input  logic [upd_pkg::CapWidth-1:0] cfg_write_data,
  input  logic                         tok_valid,
  output logic                         tok_ready,
  input  upd_pkg::tok_t                tok,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         is_final,
  output logic [upd_pkg::CharWidth-1:0] decoded_byte,
  output logic                         failed,
  output logic [upd_pkg::LenWidth-1:0] out_length
);
  import upd_pkg::*;

  logic [CapWidth-1:0]  capacity;
  phase_t               phase;
  phase_t               phase_next;
  logic [NibWidth-1:0]  high_nibble;
  logic [NibWidth-1:0]  high_nibble_next;
  logic [LenWidth-1:0]  byte_count;
  logic [LenWidth-1:0]  byte_count_next;
  logic                 stopped;
  logic                 stopped_next;
  logic                 error_seen;
  logic                 error_seen_next;

  logic                 take;
  logic                 want_emit;
  logic [CharWidth-1:0] emit_value;
  logic                 set_error;
  logic                 overflow;
  logic                 res_byte;
  logic                 res_final;
  logic [CapWidth-1:0]  cap_eff;
  logic                 out_valid_next;

  assign tok_ready = !out_valid || out_ready;
  assign take      = tok_valid && tok_ready;
  assign cap_eff   = (capacity > CapLimit) ? CapLimit : capacity;
  assign overflow  = ({1'b0, byte_count} + 13'd1) >= cap_eff;

  always_comb begin
    want_emit  = 1'b0;
    set_error  = 1'b0;
    emit_value = tok.ch;
    res_final  = 1'b0;
    if (tok.kind == KIND_END) begin
      res_final = 1'b1;
    end else if (!error_seen && !stopped) begin
      case (phase)
        PH_HI: begin
          set_error = !tok.hex_ok;
        end
        PH_LO: begin
          emit_value = {high_nibble, tok.nib};
          if (!tok.hex_ok || emit_value == '0) begin
            set_error = 1'b1;
          end else begin
            want_emit = 1'b1;
          end
        end
        default: begin
          want_emit = (tok.kind == KIND_CHAR);
        end
      endcase
    end
    res_byte = want_emit && !overflow;
    if (want_emit && overflow) begin
      set_error = 1'b1;
    end
  end

  always_comb begin
    phase_next       = phase;
    high_nibble_next = high_nibble;
    byte_count_next  = byte_count;
    stopped_next     = stopped;
    error_seen_next  = error_seen;
    if (take) begin
      if (res_final) begin
        phase_next       = PH_NORMAL;
        high_nibble_next = '0;
        byte_count_next  = '0;
        stopped_next     = 1'b0;
        error_seen_next  = 1'b0;
      end else if (!error_seen && !stopped) begin
        if (set_error) begin
          error_seen_next = 1'b1;
        end
        if (res_byte) begin
          byte_count_next = byte_count + 12'd1;
        end
        case (phase)
          PH_HI: begin
            if (tok.hex_ok) begin
              high_nibble_next = tok.nib;
              phase_next       = PH_LO;
            end else begin
              phase_next = PH_NORMAL;
            end
          end
          PH_LO: begin
            phase_next = PH_NORMAL;
          end
          default: begin
            phase_next = PH_NORMAL;
            if (tok.kind == KIND_STOP) begin
              stopped_next = 1'b1;
            end else if (tok.kind == KIND_PCT) begin
              phase_next = PH_HI;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (tok_ready) begin
      out_valid_next = take && (res_final || res_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= CapReset;
      phase       <= PH_NORMAL;
      high_nibble <= '0;
      byte_count  <= '0;
      stopped     <= 1'b0;
      error_seen  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        capacity <= cfg_write_data;
      end
      phase       <= phase_next;
      high_nibble <= high_nibble_next;
      byte_count  <= byte_count_next;
      stopped     <= stopped_next;
      error_seen  <= error_seen_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && (res_final || res_byte)) begin
      is_final     <= res_final;
      decoded_byte <= res_final ? '0 : emit_value;
      failed       <= res_final && (error_seen || phase == PH_HI || phase == PH_LO);
      out_length   <= res_final ? byte_count : '0;
    end
  end

endmodule

// ----- design/url_percent_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// url_percent_decoder_unit
// Percent-decoder for a request target, one character per transfer.
//
// Input channel (in_valid/in_ready, ch): one character per transfer, code 0
// ends the string. Output channel (out_valid/out_ready): one decoded byte per
// ordinary character or valid %XX escape before any ?, # or error, and one
// final status transfer (is_final, failed, out_length) per end character.
// Configuration: cfg_write_en/cfg_write_data set the output capacity.
// The input register loads when the character is accepted, then the queue
// entry, then the result register, where out_valid rises.
// Throughput: one character per cycle while the receiver does not stall,
// set by the state update in the back part.
// Reset: clears the decode state, empties the queue and sets the capacity
// to 2048. When the receiver stalls, the result register holds, the back
// part stops taking tokens, the queue fills and then in_ready drops.
// ----------------------------------------------------------------------------
module url_percent_decoder_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [upd_pkg::CapWidth-1:0]  cfg_write_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [upd_pkg::CharWidth-1:0] ch,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          is_final,
  output logic [upd_pkg::CharWidth-1:0] decoded_byte,
  output logic                          failed,
  output logic [upd_pkg::LenWidth-1:0]  out_length
);
  import upd_pkg::*;

  logic f_valid;
  logic f_ready;
  tok_t f_tok;
  logic q_valid;
  logic q_ready;
  tok_t q_tok;

  upd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ch        (ch),
    .tok_valid (f_valid),
    .tok_ready (f_ready),
    .tok       (f_tok)
  );

  upd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_tok   (f_tok),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_tok    (q_tok)
  );

  upd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .tok_valid      (q_valid),
    .tok_ready      (q_ready),
    .tok            (q_tok),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .is_final       (is_final),
    .decoded_byte   (decoded_byte),
    .failed         (failed),
    .out_length     (out_length)
  );

endmodule
